>>> rtl/efmd_pkg.sv
// Shared types, constants and the EFM code table for the EFM frame demodulator.
// No dependencies; every other file of the block but efmd_chan_if imports this package.
`default_nettype none

package efmd_pkg;

	localparam int SymbolsPerFrameDef = 33;
	localparam int FrameBytesDef = 74;
	localparam int CodeBits = 14;
	localparam int SyncSkip = 24 + 3;
	localparam int SymbolPitch = 14 + 3;

	typedef logic [CodeBits-1:0] code_t;
	typedef logic [5:0] sym_idx_t;

	localparam code_t Sync0Code = 14'h0801;
	localparam code_t Sync1Code = 14'h0012;
	localparam logic [3:0] RunMin = 4'd3;
	localparam logic [3:0] RunMax = 4'd11;

	typedef struct packed {
		logic [3:0] run_length;
		logic       frame_end;
	} efmd_in_t;

	typedef struct packed {
		sym_idx_t   symbol_index;
		logic [7:0] symbol_value;
		logic       symbol_error;
		logic       sync_zero;
		logic       sync_one;
		logic       last_symbol;
	} efmd_out_t;

	// One queue entry: an optional completed symbol, then an optional flush of the
	// remaining symbols of the frame starting at flush_start.
	typedef struct packed {
		logic     emit_v;
		sym_idx_t emit_index;
		code_t    emit_code;
		logic     flush_v;
		sym_idx_t flush_start;
		code_t    flush_code;
	} efmd_cmd_t;

	localparam code_t EfmCodes [256] = '{
		14'h1220, 14'h2100, 14'h2420, 14'h2220, 14'h1100, 14'h0110, 14'h0420, 14'h0900,
		14'h1240, 14'h2040, 14'h2440, 14'h2240, 14'h1040, 14'h0040, 14'h0440, 14'h0840,
		14'h2020, 14'h2080, 14'h2480, 14'h0820, 14'h1080, 14'h0080, 14'h0480, 14'h0880,
		14'h1210, 14'h2010, 14'h2410, 14'h2210, 14'h1010, 14'h0210, 14'h0410, 14'h0810,
		14'h0020, 14'h2108, 14'h0220, 14'h0920, 14'h1108, 14'h0108, 14'h1020, 14'h0908,
		14'h1248, 14'h2048, 14'h2448, 14'h2248, 14'h1048, 14'h0048, 14'h0448, 14'h0848,
		14'h0100, 14'h2088, 14'h2488, 14'h2110, 14'h1088, 14'h0088, 14'h0488, 14'h0888,
		14'h1208, 14'h2008, 14'h2408, 14'h2208, 14'h1008, 14'h0208, 14'h0408, 14'h0808,
		14'h1224, 14'h2124, 14'h2424, 14'h2224, 14'h1124, 14'h0024, 14'h0424, 14'h0924,
		14'h1244, 14'h2044, 14'h2444, 14'h2244, 14'h1044, 14'h0044, 14'h0444, 14'h0844,
		14'h2024, 14'h2084, 14'h2484, 14'h0824, 14'h1084, 14'h0084, 14'h0484, 14'h0884,
		14'h1204, 14'h2004, 14'h2404, 14'h2204, 14'h1004, 14'h0204, 14'h0404, 14'h0804,
		14'h1222, 14'h2122, 14'h2422, 14'h2222, 14'h1122, 14'h0022, 14'h1024, 14'h0922,
		14'h1242, 14'h2042, 14'h2442, 14'h2242, 14'h1042, 14'h0042, 14'h0442, 14'h0842,
		14'h2022, 14'h2082, 14'h2482, 14'h0822, 14'h1082, 14'h0082, 14'h0482, 14'h0882,
		14'h1202, 14'h0248, 14'h2402, 14'h2202, 14'h1002, 14'h0202, 14'h0402, 14'h0802,
		14'h1221, 14'h2121, 14'h2421, 14'h2221, 14'h1121, 14'h0021, 14'h0421, 14'h0921,
		14'h1241, 14'h2041, 14'h2441, 14'h2241, 14'h1041, 14'h0041, 14'h0441, 14'h0841,
		14'h2021, 14'h2081, 14'h2481, 14'h0821, 14'h1081, 14'h0081, 14'h0481, 14'h0881,
		14'h1201, 14'h2090, 14'h2401, 14'h2201, 14'h1001, 14'h0201, 14'h0401, 14'h0801,
		14'h0910, 14'h2109, 14'h0221, 14'h1110, 14'h1109, 14'h0109, 14'h1021, 14'h0909,
		14'h1249, 14'h2049, 14'h2449, 14'h2249, 14'h1049, 14'h0049, 14'h0449, 14'h0849,
		14'h0200, 14'h2089, 14'h2489, 14'h0249, 14'h1089, 14'h0089, 14'h0489, 14'h0889,
		14'h1209, 14'h2009, 14'h2409, 14'h2209, 14'h1009, 14'h0209, 14'h0409, 14'h0809,
		14'h1120, 14'h2111, 14'h2490, 14'h0224, 14'h1111, 14'h0111, 14'h0490, 14'h0911,
		14'h0241, 14'h2101, 14'h0244, 14'h0240, 14'h1101, 14'h0101, 14'h0090, 14'h0901,
		14'h0242, 14'h2091, 14'h2491, 14'h2120, 14'h1091, 14'h0091, 14'h0491, 14'h0891,
		14'h1211, 14'h2011, 14'h2411, 14'h2211, 14'h1011, 14'h0211, 14'h0411, 14'h0811,
		14'h1112, 14'h2112, 14'h2492, 14'h0112, 14'h1092, 14'h0092, 14'h0492, 14'h0892,
		14'h0912, 14'h2092, 14'h0122, 14'h0124, 14'h0121, 14'h0102, 14'h0104, 14'h0904,
		14'h0902, 14'h2102, 14'h2104, 14'h1102, 14'h1104, 14'h0120, 14'h0890, 14'h1090,
		14'h1212, 14'h2012, 14'h2412, 14'h2212, 14'h1012, 14'h0212, 14'h0412, 14'h0812
	};

	// Compares a code against every table entry; bit i is set when entry i matches.
	function automatic logic [255:0] efm_match(code_t code);
		logic [255:0] m;
		for (int i = 0; i < 256; i++) begin
			m[i] = (EfmCodes[i] == code);
		end
		return m;
	endfunction

	// Index of the lowest set bit, so that the smallest matching byte wins.
	function automatic logic [7:0] lowest_set(logic [255:0] m);
		logic [7:0] r;
		r = '0;
		for (int i = 255; i >= 0; i--) begin
			if (m[i]) begin
				r = 8'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/efmd_chan_if.sv
// Valid/ready channel interface used for the run and symbol channels.
// The payload type is given by the instance; no other dependencies.
`default_nettype none

interface efmd_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/efmd_front.sv
// Front part: accepts run lengths, tracks the channel bit position of the frame and
// collects code bits; writes symbol and flush commands into the queue. Uses efmd_pkg.
`default_nettype none

module efmd_front
	import efmd_pkg::*;
#(
	parameter int SYMBOLS_PER_FRAME = SymbolsPerFrameDef,
	parameter int FRAME_BYTES = FrameBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	efmd_chan_if.sink   runs,
	input  logic        full,
	output logic        push,
	output efmd_cmd_t   cmd
);

	localparam int LimitRaw = FRAME_BYTES * 8;
	localparam logic [9:0] Limit = 10'((LimitRaw > 1023) ? 1023 : LimitRaw);
	localparam logic [9:0] SyncStart = 10'(SyncSkip);
	localparam code_t CodeMsb = code_t'(1) << (CodeBits - 1);

	logic [9:0] pos_q;
	logic [5:0] k_q;
	logic [4:0] r_q;
	code_t      cw_q;
	sym_idx_t   ns_q;

	logic [3:0]  run;
	logic [3:0]  n;
	logic [9:0]  rem;
	logic [10:0] pos_sum;
	logic [9:0]  pos_nx;
	logic [5:0]  r_sum;
	logic [5:0]  k_nx;
	logic [4:0]  r_nx;
	logic        in_sync;
	logic        in_win;
	logic        emit;
	logic        accept;
	code_t       set_bit;
	code_t       cw_or;
	sym_idx_t    ns_nx;

	assign runs.ready = !full;
	assign accept = runs.valid && runs.ready;

	always_comb begin
		if (runs.payload.run_length < RunMin) begin
			run = RunMin;
		end else if (runs.payload.run_length > RunMax) begin
			run = RunMax;
		end else begin
			run = runs.payload.run_length;
		end

		// Bits past the frame limit are dropped.
		rem = Limit - pos_q;
		n = (rem >= 10'(run)) ? run : rem[3:0];
		pos_sum = {1'b0, pos_q} + 11'(n);
		pos_nx = pos_sum[9:0];

		// k_q and r_q are the symbol and offset within its 17-bit slot at pos_q.
		in_sync = (pos_q < SyncStart);
		r_sum = {1'b0, r_q} + 6'(n);
		if (in_sync) begin
			k_nx = '0;
			r_nx = (pos_nx >= SyncStart) ? 5'(pos_nx - SyncStart) : '0;
		end else if (r_sum >= 6'(SymbolPitch)) begin
			k_nx = k_q + 6'd1;
			r_nx = 5'(r_sum - 6'(SymbolPitch));
		end else begin
			k_nx = k_q;
			r_nx = r_sum[4:0];
		end

		// Only the first bit of a run is a one, and a run of at most eleven bits
		// can finish a code only when that first bit already lies inside the code.
		in_win = (n != '0) && !in_sync && (k_q < 6'(SYMBOLS_PER_FRAME))
			&& (r_q < 5'(CodeBits));
		set_bit = in_win ? (CodeMsb >> r_q) : '0;
		cw_or = cw_q | set_bit;
		emit = in_win && (r_sum >= 6'(CodeBits));
		ns_nx = emit ? ns_q + 6'd1 : ns_q;

		cmd.emit_v = emit;
		cmd.emit_index = ns_q;
		cmd.emit_code = cw_or;
		cmd.flush_v = runs.payload.frame_end && (ns_nx < 6'(SYMBOLS_PER_FRAME));
		cmd.flush_start = ns_nx;
		cmd.flush_code = emit ? '0 : cw_or;
	end

	assign push = accept && (cmd.emit_v || cmd.flush_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			k_q <= '0;
			r_q <= '0;
			cw_q <= '0;
			ns_q <= '0;
		end else if (accept) begin
			if (runs.payload.frame_end) begin
				pos_q <= '0;
				k_q <= '0;
				r_q <= '0;
				cw_q <= '0;
				ns_q <= '0;
			end else begin
				pos_q <= pos_nx;
				k_q <= k_nx;
				r_q <= r_nx;
				cw_q <= emit ? '0 : cw_or;
				ns_q <= ns_nx;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/efmd_queue.sv
// Short command queue between the front and back parts of the demodulator.
// Holds efmd_cmd_t entries from efmd_pkg.
`default_nettype none

module efmd_queue
	import efmd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  efmd_cmd_t push_cmd,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output efmd_cmd_t head
);

	localparam int Depth = 4;
	localparam int PtrW = $clog2(Depth);

	efmd_cmd_t       mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [PtrW:0]   cnt_q;

	assign full = (cnt_q == (PtrW + 1)'(Depth));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/efmd_back.sv
// Back part: expands queue commands into one symbol per unstalled cycle and decodes
// each code through the EFM table in a three-stage pipeline. Uses efmd_pkg, efmd_chan_if.
`default_nettype none

module efmd_back
	import efmd_pkg::*;
#(
	parameter int SYMBOLS_PER_FRAME = SymbolsPerFrameDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  efmd_cmd_t    head,
	output logic         pop,
	efmd_chan_if.source  symbols
);

	localparam sym_idx_t LastIdx = sym_idx_t'(SYMBOLS_PER_FRAME - 1);

	typedef enum logic [1:0] {
		SEQ_HEAD  = 2'b01,
		SEQ_FLUSH = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t state_d;
	sym_idx_t   fl_idx_q;
	sym_idx_t   fl_idx_d;
	sym_idx_t   cur_idx;

	logic     en;
	logic     iss_v;
	sym_idx_t iss_idx;
	code_t    iss_code;

	logic         v_s1;
	sym_idx_t     idx_s1;
	code_t        code_s1;
	logic         v_s2;
	sym_idx_t     idx_s2;
	logic [255:0] match_s2;
	logic         sy0_s2;
	logic         sy1_s2;
	logic         v_s3;
	efmd_out_t    out_s3;

	// The whole pipeline holds while the output word waits to be taken.
	assign en = !v_s3 || symbols.ready;

	always_comb begin
		state_d = state_q;
		fl_idx_d = fl_idx_q;
		pop = 1'b0;
		iss_v = 1'b0;
		iss_idx = '0;
		iss_code = '0;
		cur_idx = (state_q == SEQ_FLUSH) ? fl_idx_q : head.flush_start;
		if (en && !empty) begin
			iss_v = 1'b1;
			if (state_q == SEQ_HEAD && head.emit_v) begin
				iss_idx = head.emit_index;
				iss_code = head.emit_code;
				if (head.flush_v) begin
					state_d = SEQ_FLUSH;
					fl_idx_d = head.flush_start;
				end else begin
					pop = 1'b1;
				end
			end else begin
				// Only the first flushed symbol can hold the bits of a partial code.
				iss_idx = cur_idx;
				iss_code = (cur_idx == head.flush_start) ? head.flush_code : '0;
				if (cur_idx == LastIdx) begin
					pop = 1'b1;
					state_d = SEQ_HEAD;
				end else begin
					state_d = SEQ_FLUSH;
					fl_idx_d = cur_idx + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_HEAD;
			fl_idx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			state_q <= state_d;
			fl_idx_q <= fl_idx_d;
			if (en) begin
				v_s1 <= iss_v;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= iss_idx;
			code_s1 <= iss_code;

			idx_s2 <= idx_s1;
			match_s2 <= efm_match(code_s1);
			sy0_s2 <= (idx_s1 == '0) && (code_s1 == Sync0Code);
			sy1_s2 <= (idx_s1 == '0) && (code_s1 == Sync1Code);

			out_s3.symbol_index <= idx_s2;
			out_s3.sync_zero <= sy0_s2;
			out_s3.sync_one <= sy1_s2;
			out_s3.symbol_value <= (sy0_s2 || sy1_s2 || !(|match_s2)) ? '0
				: lowest_set(match_s2);
			out_s3.symbol_error <= !(sy0_s2 || sy1_s2) && !(|match_s2);
			out_s3.last_symbol <= (idx_s2 == LastIdx);
		end
	end

	assign symbols.valid = v_s3;
	assign symbols.payload = out_s3;

endmodule

`default_nettype wire

>>> rtl/efm_frame_demodulator_unit.sv
// EFM frame demodulator: top level joining front, command queue and back parts.
// Depends on efmd_pkg, efmd_chan_if, efmd_front, efmd_queue and efmd_back.
//
// Usage: runs carries one channel run length per word (run_length clamped to
// 3..11, frame_end on the last run of a frame). symbols carries one decoded word
// per EFM symbol: index 0 is the subcode symbol with its sync flags, 1..32 data.
// A symbol word is registered in the command queue and then in the three decode
// stages after the run that completes its 14th code bit is accepted.
// One run is accepted every cycle unless the queue is full; a run can complete
// at most one code. On frame_end all symbols not yet delivered are sent by the
// flush sequencer in the back part, one per cycle while the receiver takes them.
// A four-entry command queue lets runs keep flowing during the flush.
// When the receiver stalls, the output register and the decode pipeline hold,
// the queue fills and runs.ready drops once it is full.
// Reset clears the bit position, the code bits, the symbol count, the queue and
// all output valids; no symbol is pending after reset.
`default_nettype none

module efm_frame_demodulator_unit
	import efmd_pkg::*;
#(
	parameter int SYMBOLS_PER_FRAME = SymbolsPerFrameDef,
	parameter int FRAME_BYTES = FrameBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	efmd_chan_if.sink   runs,
	efmd_chan_if.source symbols
);

	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	efmd_cmd_t push_cmd;
	efmd_cmd_t head;

	efmd_front #(
		.SYMBOLS_PER_FRAME(SYMBOLS_PER_FRAME),
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.runs(runs),
		.full(full),
		.push(push),
		.cmd(push_cmd)
	);

	efmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.full(full),
		.empty(empty),
		.head(head)
	);

	efmd_back #(
		.SYMBOLS_PER_FRAME(SYMBOLS_PER_FRAME)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.symbols(symbols)
	);

endmodule

`default_nettype wire

>>> rtl/efmd_checker.sv
// Port-level checks for the EFM frame demodulator, bound to its top level.
// Uses efmd_pkg for the symbol word type.
`default_nettype none

module efmd_checker
	import efmd_pkg::*;
#(
	parameter int SYMBOLS_PER_FRAME = SymbolsPerFrameDef
) (
	input logic      clk,
	input logic      arst_n,
	input logic      sym_valid,
	input logic      sym_ready,
	input efmd_out_t sym
);

	localparam sym_idx_t LastIdx = sym_idx_t'(SYMBOLS_PER_FRAME - 1);

	// A stalled symbol word stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && !sym_ready |=> sym_valid && $stable(sym))
		else $error("symbol word changed while stalled");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid |-> (sym.symbol_index <= LastIdx)
			&& (sym.last_symbol == (sym.symbol_index == LastIdx)))
		else $error("symbol index or last flag out of line");

	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && (sym.sync_zero || sym.sync_one) |-> (sym.symbol_index == '0)
			&& (sym.symbol_value == '0) && !sym.symbol_error
			&& !(sym.sync_zero && sym.sync_one))
		else $error("sync flag on a symbol that cannot carry it");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym.symbol_error |-> (sym.symbol_value == '0))
		else $error("invalid code with a nonzero value");

endmodule

bind efm_frame_demodulator_unit efmd_checker #(
	.SYMBOLS_PER_FRAME(SYMBOLS_PER_FRAME)
) u_efmd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sym_valid(symbols.valid),
	.sym_ready(symbols.ready),
	.sym(symbols.payload)
);

`default_nettype wire
